FILE: rtl/assert_macros.svh
// Assertion macros shared by the scene radiance recovery RTL.
// The macros sample on clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SRR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scene radiance recovery: assertion failed");

`define SRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scene radiance recovery: assertion failed");

`else

`define SRR_ASSERT_IMPLY(label, ante, cons)

`define SRR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/srr_pkg.sv
// Package for the scene radiance recovery block: widths, register indexes,
// payload structs and the per-channel divider lane record. No dependencies.
package srr_pkg;

  localparam int TRANS_FRAC_BITS = 14;

  localparam int PIX_W   = 8;
  localparam int ATM_W   = 16;
  localparam int TR_W    = 15;
  localparam int NUM_CH  = 3;
  localparam int PROD_W  = ATM_W + TR_W;
  localparam int DIFF_W  = ATM_W + 1;

  // Positive numerator stays below 2^(16+F) + 2^31.
  localparam int NUM_W   = ((ATM_W + TRANS_FRAC_BITS) > PROD_W ?
                            (ATM_W + TRANS_FRAC_BITS) : PROD_W) + 1;
  localparam int SNUM_W  = NUM_W + 1;

  // One quotient bit per divider stage.
  localparam int DIV_STEPS = PIX_W;
  localparam int SAT_SHIFT = 2 * PIX_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ATM_W;

  localparam logic [CFG_IDX_W-1:0] REG_ATMOS_BLUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATMOS_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATMOS_RED   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_FLOOR = 2'd3;

  localparam logic [ATM_W-1:0] ATMOS_RESET = 16'hFF00;
  localparam logic [TR_W-1:0]  FLOOR_RESET = 15'd1638;

  typedef struct packed {
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_red;
    logic [TR_W-1:0]  transmission;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
  } pixel_out_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [PIX_W-1:0] quo;
    logic             zero;
    logic             sat;
  } div_lane_t;

endpackage

FILE: rtl/scene_radiance_recover.sv
// Top level of the scene radiance recovery block: a fully pipelined datapath.
// Depends on srr_pkg and on assert_macros.svh.

// Recovers scene radiance J = (I - A) / max(t, floor) + A for each BGR
// channel of a pixel, rounded to nearest (ties to even) and clamped to
// 0..255. The datapath is a 12-stage pipeline: transmission floor and
// difference, a 16x15 multiply, the numerator sum with range checks, eight
// restoring divider stages that each settle one quotient bit, and a rounding
// stage that feeds the output register. One pixel is accepted every clock
// while the output is not stalled. Stalls collapse bubbles stage by stage.
// Configuration registers are read directly by the datapath and are to be
// written while no pixel is in flight; the user must keep to this, as the
// block itself does not enforce it.
module scene_radiance_recover (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_stall,
  input  srr_pkg::pixel_in_t              pix_data,
  output logic                            rad_valid,
  input  logic                            rad_stall,
  output srr_pkg::pixel_out_t             rad_data,
  input  logic                            cfg_wr_en,
  input  logic [srr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import srr_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [ATM_W-1:0] atmos_blue;
  logic [ATM_W-1:0] atmos_green;
  logic [ATM_W-1:0] atmos_red;
  logic [TR_W-1:0]  trans_floor;

  logic [ATM_W-1:0] atm    [NUM_CH];
  logic [PIX_W-1:0] pix_ch [NUM_CH];

  // Stage 1: floored transmission and signed differences.
  logic                     v1;
  logic [TR_W-1:0]          t1;
  logic signed [DIFF_W-1:0] d1 [NUM_CH];

  // Stage 2: products of atmospheric light and transmission.
  logic                     v2;
  logic [TR_W-1:0]          t2;
  logic signed [DIFF_W-1:0] d2 [NUM_CH];
  logic [PROD_W-1:0]        prod2 [NUM_CH];

  // Divider stages; index 0 holds the numerator stage.
  logic [DIV_STEPS:0]       dv_valid;
  logic [TR_W-1:0]          dv_t    [DIV_STEPS+1];
  div_lane_t                dv_lane [DIV_STEPS+1][NUM_CH];

  // Ready chain.
  logic                     out_ready;
  logic                     s1_ready;
  logic                     s2_ready;
  logic [DIV_STEPS:0]       dv_ready;

  // Combinational next values.
  logic [TR_W-1:0]          floor_eff;
  logic [TR_W-1:0]          t_eff;
  logic signed [DIFF_W-1:0] d_next   [NUM_CH];
  div_lane_t                num_lane [NUM_CH];
  div_lane_t                step_lane [DIV_STEPS+1][NUM_CH];
  pixel_out_t               res_next;
  logic                     rem_ok;
  logic                     flags_ok;

  assign atm[0]    = atmos_blue;
  assign atm[1]    = atmos_green;
  assign atm[2]    = atmos_red;
  assign pix_ch[0] = pix_data.in_blue;
  assign pix_ch[1] = pix_data.in_green;
  assign pix_ch[2] = pix_data.in_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      atmos_blue  <= ATMOS_RESET;
      atmos_green <= ATMOS_RESET;
      atmos_red   <= ATMOS_RESET;
      trans_floor <= FLOOR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ATMOS_BLUE:  atmos_blue  <= cfg_wdata[ATM_W-1:0];
        REG_ATMOS_GREEN: atmos_green <= cfg_wdata[ATM_W-1:0];
        REG_ATMOS_RED:   atmos_red   <= cfg_wdata[ATM_W-1:0];
        REG_TRANS_FLOOR: trans_floor <= cfg_wdata[TR_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage takes new data when it is empty or its successor moves.
  always_comb begin
    out_ready = !rad_valid || !rad_stall;
    dv_ready[DIV_STEPS] = !dv_valid[DIV_STEPS] || out_ready;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      dv_ready[k] = !dv_valid[k] || dv_ready[k+1];
    end
    s2_ready = !v2 || dv_ready[0];
    s1_ready = !v1 || s2_ready;
  end

  assign pix_stall = !s1_ready;

  // Stage 1 logic. A zero floor register acts as one LSB.
  always_comb begin
    floor_eff = (trans_floor == '0) ? TR_W'(1) : trans_floor;
    t_eff = (pix_data.transmission < floor_eff) ? floor_eff : pix_data.transmission;
    for (int c = 0; c < NUM_CH; c++) begin
      d_next[c] = $signed({1'b0, pix_ch[c], 8'h00}) - $signed({1'b0, atm[c]});
    end
  end

  // Numerator stage: num = d * 2^F + A * t, with range flags.
  always_comb begin
    logic signed [SNUM_W-1:0] num_s;
    logic [NUM_W-1:0]         num_u;
    for (int c = 0; c < NUM_CH; c++) begin
      num_s = (SNUM_W'(d2[c]) <<< TRANS_FRAC_BITS) + $signed(SNUM_W'(prod2[c]));
      num_u = num_s[NUM_W-1:0];
      num_lane[c].rem  = num_u;
      num_lane[c].quo  = '0;
      num_lane[c].zero = num_s[SNUM_W-1] || (num_s == '0);
      num_lane[c].sat  = !num_lane[c].zero && (num_u >= (NUM_W'(t2) << SAT_SHIFT));
    end
  end

  // Restoring divider: stage k settles quotient bit DIV_STEPS-k against
  // the divisor 256*t shifted into place.
  always_comb begin
    logic [NUM_W-1:0] trial;
    for (int c = 0; c < NUM_CH; c++) begin
      step_lane[0][c] = num_lane[c];
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      trial = NUM_W'(dv_t[k-1]) << (PIX_W + DIV_STEPS - k);
      for (int c = 0; c < NUM_CH; c++) begin
        step_lane[k][c] = dv_lane[k-1][c];
        if (dv_lane[k-1][c].rem >= trial) begin
          step_lane[k][c].rem = dv_lane[k-1][c].rem - trial;
          step_lane[k][c].quo[DIV_STEPS-k] = 1'b1;
        end
      end
    end
  end

  // Rounding: the remainder is compared with half the divisor, 128*t.
  always_comb begin
    logic [NUM_W-1:0] half;
    logic             rnd;
    logic [PIX_W-1:0] val [NUM_CH];
    half = NUM_W'(dv_t[DIV_STEPS]) << (PIX_W - 1);
    for (int c = 0; c < NUM_CH; c++) begin
      rnd = (dv_lane[DIV_STEPS][c].rem > half) ||
            ((dv_lane[DIV_STEPS][c].rem == half) && dv_lane[DIV_STEPS][c].quo[0]);
      if (dv_lane[DIV_STEPS][c].sat) begin
        val[c] = '1;
      end else if (dv_lane[DIV_STEPS][c].zero) begin
        val[c] = '0;
      end else if (dv_lane[DIV_STEPS][c].quo == '1) begin
        val[c] = '1;
      end else begin
        val[c] = dv_lane[DIV_STEPS][c].quo + PIX_W'(rnd);
      end
    end
    res_next.out_blue  = val[0];
    res_next.out_green = val[1];
    res_next.out_red   = val[2];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      dv_valid  <= '0;
      rad_valid <= 1'b0;
    end else begin
      if (s1_ready) v1 <= pix_valid;
      if (s2_ready) v2 <= v1;
      if (dv_ready[0]) dv_valid[0] <= v2;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        if (dv_ready[k]) dv_valid[k] <= dv_valid[k-1];
      end
      if (out_ready) rad_valid <= dv_valid[DIV_STEPS];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_ready && pix_valid) begin
      t1 <= t_eff;
      for (int c = 0; c < NUM_CH; c++) d1[c] <= d_next[c];
    end
    if (s2_ready && v1) begin
      t2 <= t1;
      for (int c = 0; c < NUM_CH; c++) begin
        d2[c]    <= d1[c];
        prod2[c] <= PROD_W'(atm[c]) * PROD_W'(t1);
      end
    end
    if (dv_ready[0] && v2) begin
      dv_t[0] <= t2;
      for (int c = 0; c < NUM_CH; c++) dv_lane[0][c] <= step_lane[0][c];
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (dv_ready[k] && dv_valid[k-1]) begin
        dv_t[k] <= dv_t[k-1];
        for (int c = 0; c < NUM_CH; c++) dv_lane[k][c] <= step_lane[k][c];
      end
    end
    if (out_ready && dv_valid[DIV_STEPS]) begin
      rad_data <= res_next;
    end
  end

  // Checks on the divider: in-range lanes end with a remainder below the
  // divisor, and a lane is never both non-positive and saturated.
  always_comb begin
    rem_ok   = 1'b1;
    flags_ok = 1'b1;
    for (int c = 0; c < NUM_CH; c++) begin
      if (!dv_lane[DIV_STEPS][c].zero && !dv_lane[DIV_STEPS][c].sat &&
          (dv_lane[DIV_STEPS][c].rem >= (NUM_W'(dv_t[DIV_STEPS]) << PIX_W))) begin
        rem_ok = 1'b0;
      end
      if (dv_lane[0][c].zero && dv_lane[0][c].sat) begin
        flags_ok = 1'b0;
      end
    end
  end

  `SRR_ASSERT_IMPLY(a_rem_below_divisor, dv_valid[DIV_STEPS], rem_ok)
  `SRR_ASSERT_IMPLY(a_flags_exclusive, dv_valid[0], flags_ok)
  `SRR_ASSERT_NEXT(a_last_stage_drains, dv_valid[DIV_STEPS] && !rad_valid, rad_valid)

endmodule

FILE: tb/srr_radiance_checker.sv
// Checker for the scene radiance recovery block: watches the pixel, radiance
// and configuration ports, predicts each recovered pixel and compares it.
// Depends on srr_pkg for the payload structs and register indexes.
module srr_radiance_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pix_valid,
  input  logic                           pix_stall,
  input  srr_pkg::pixel_in_t             pix_data,
  input  logic                           rad_valid,
  input  logic                           rad_stall,
  input  srr_pkg::pixel_out_t            rad_data,
  input  logic                           cfg_wr_en,
  input  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             outstanding
);
  import srr_pkg::*;

  // Local copy of the configuration registers.
  logic [ATM_W-1:0] atm_blue  = ATMOS_RESET;
  logic [ATM_W-1:0] atm_green = ATMOS_RESET;
  logic [ATM_W-1:0] atm_red   = ATMOS_RESET;
  logic [TR_W-1:0]  min_trans = FLOOR_RESET;

  pixel_out_t radiance_q[$];
  int mismatches = 0;
  int queued = 0;

  assign fail_count  = mismatches;
  assign outstanding = queued;

  // Exact rational J = (d * 2^F + A * t) / (256 * t), rounded half to even.
  function automatic logic [PIX_W-1:0] recover_level(logic [PIX_W-1:0] level,
                                                     logic [ATM_W-1:0] atm,
                                                     logic [TR_W-1:0] divisor);
    longint diff, numer, denom, quo, rem;
    diff  = longint'(level) * 256 - longint'(atm);
    numer = diff * (longint'(1) << TRANS_FRAC_BITS) + longint'(atm) * longint'(divisor);
    denom = longint'(divisor) * 256;
    if (numer <= 0) return '0;
    quo = numer / denom;
    rem = numer % denom;
    if (2 * rem > denom || (2 * rem == denom && (quo % 2) != 0)) quo++;
    if (quo > 255) quo = 255;
    return quo[PIX_W-1:0];
  endfunction

  function automatic pixel_out_t predict_radiance(pixel_in_t px);
    logic [TR_W-1:0] floor_eff, t_eff;
    pixel_out_t res;
    // A zero floor still divides by one LSB.
    floor_eff = (min_trans == '0) ? TR_W'(1) : min_trans;
    t_eff = (px.transmission < floor_eff) ? floor_eff : px.transmission;
    res.out_blue  = recover_level(px.in_blue, atm_blue, t_eff);
    res.out_green = recover_level(px.in_green, atm_green, t_eff);
    res.out_red   = recover_level(px.in_red, atm_red, t_eff);
    return res;
  endfunction

  task automatic check_field(string name, logic [PIX_W-1:0] exp_v, logic [PIX_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_out_t want;
    if (rst) begin
      radiance_q.delete();
    end else begin
      if (rad_valid && !rad_stall) begin
        if (radiance_q.size() == 0) begin
          $error("radiance transfer with no pixel outstanding: %h", rad_data);
          mismatches++;
        end else begin
          want = radiance_q.pop_front();
          check_field("out_blue", want.out_blue, rad_data.out_blue);
          check_field("out_green", want.out_green, rad_data.out_green);
          check_field("out_red", want.out_red, rad_data.out_red);
        end
      end
      if (pix_valid && !pix_stall) radiance_q.push_back(predict_radiance(pix_data));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ATMOS_BLUE:  atm_blue  = cfg_wdata;
          REG_ATMOS_GREEN: atm_green = cfg_wdata;
          REG_ATMOS_RED:   atm_red   = cfg_wdata;
          REG_TRANS_FLOOR: min_trans = cfg_wdata[TR_W-1:0];
          default: ;
        endcase
      end
    end
    queued = radiance_q.size();
  end

endmodule

FILE: tb/tb_scene_radiance_recover.sv
// Testbench top for scene_radiance_recover: drives pixels, stalls and
// register writes, and reports the verdict from srr_radiance_checker.
// Depends on srr_pkg, the block and the checker module.
module tb_scene_radiance_recover;
  import srr_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 30;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  pixel_in_t             pix_data = '0;
  logic                  rad_valid;
  logic                  rad_stall = 1'b0;
  pixel_out_t            rad_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ATMOS_BLUE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;

  // Idling controls; hold_done is written by the radiance side, the rest by the stimulus.
  bit tx_jitter = 1'b0;
  bit rx_jitter = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  always #1 clk = ~clk;

  scene_radiance_recover u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .rad_valid (rad_valid),
    .rad_stall (rad_stall),
    .rad_data  (rad_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  srr_radiance_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pix_data    (pix_data),
    .rad_valid   (rad_valid),
    .rad_stall   (rad_stall),
    .rad_data    (rad_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Ends the run when no transfer or register write happens for too long.
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (rad_valid && !rad_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_scene_radiance_recover NOT OK");
      $finish;
    end
  end

  // Radiance side: random stalls, plus one long hold-off on request.
  initial begin
    int pick;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        rad_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        rad_stall = 1'b0;
        hold_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (!rx_jitter || pick < 60) begin
          rad_stall = 1'b0;
        end else if (pick < 95) begin
          rad_stall = 1'b1;
          repeat ($urandom_range(1, 4)) @(negedge clk);
          rad_stall = 1'b0;
        end else begin
          rad_stall = 1'b1;
          repeat ($urandom_range(10, 60)) @(negedge clk);
          rad_stall = 1'b0;
        end
      end
    end
  end

  function automatic int tx_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (!tx_jitter || pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_in_t make_pixel(int b, int g, int r, int t);
    pixel_in_t px;
    px.in_blue      = PIX_W'(b);
    px.in_green     = PIX_W'(g);
    px.in_red       = PIX_W'(r);
    px.transmission = TR_W'(t);
    return px;
  endfunction

  function automatic int rand_level();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // Transmission is drawn around the floor and around 1.0 most of the time.
  function automatic pixel_in_t rand_pixel(int floor_v);
    int pick, lo, hi, t;
    pick = $urandom_range(0, 9);
    lo = (floor_v < 16384) ? floor_v : 16384;
    hi = (floor_v < 16384) ? 16384 : floor_v;
    if (pick < 2) t = $urandom_range(0, floor_v);
    else if (pick < 7) t = $urandom_range(lo, hi);
    else if (pick == 7) t = 16384;
    else t = $urandom_range(0, 32767);
    return make_pixel(rand_level(), rand_level(), rand_level(), t);
  endfunction

  task automatic send_pixel(pixel_in_t px, int gap);
    @(negedge clk);
    if (gap > 0) begin
      pix_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid = 1'b1;
    pix_data  = px;
    do @(posedge clk); while (pix_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    pix_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_config(int blue, int green, int red, int floor_v);
    cfg_write(REG_ATMOS_BLUE, blue);
    cfg_write(REG_ATMOS_GREEN, green);
    cfg_write(REG_ATMOS_RED, red);
    cfg_write(REG_TRANS_FLOOR, floor_v);
  endtask

  initial begin
    int trans_pts[8];
    int atm_b, atm_g, atm_r, floor_v;
    trans_pts = '{0, 1, 1637, 1638, 8192, 16383, 16384, 32767};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset configuration: transmission below, at and above the floor.
    foreach (trans_pts[k]) begin
      send_pixel(make_pixel(0, 255, 128, trans_pts[k]), 0);
      send_pixel(make_pixel(255, 1, 0, trans_pts[k]), 0);
    end
    drain();

    // Half-LSB light at t = 0.5 lands exactly between two integers.
    set_config(128, 128, 128, 1638);
    send_pixel(make_pixel(10, 11, 100, 8192), 0);
    send_pixel(make_pixel(37, 200, 255, 8192), 0);
    drain();

    // Zero floor and light above the nominal range.
    set_config(65535, 65535, 65535, 0);
    send_pixel(make_pixel(0, 255, 17, 0), 0);
    send_pixel(make_pixel(200, 100, 50, 32767), 0);
    drain();

    set_config(0, 0, 0, 16384);
    send_pixel(make_pixel(255, 0, 77, 1), 0);
    send_pixel(make_pixel(128, 64, 32, 16384), 0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin atm_b = 65280; atm_g = 65280; atm_r = 65280; floor_v = 1638; end
        1: begin atm_b = 0; atm_g = 0; atm_r = 0; floor_v = 1; end
        2: begin atm_b = 65280; atm_g = 65280; atm_r = 65280; floor_v = 16384; end
        3: begin atm_b = 65535; atm_g = 0; atm_r = 65535; floor_v = 32767; end
        default: begin
          atm_b   = $urandom_range(0, 65280);
          atm_g   = $urandom_range(0, 65280);
          atm_r   = $urandom_range(0, 65280);
          floor_v = $urandom_range(1, 16384);
        end
      endcase
      set_config(atm_b, atm_g, atm_r, floor_v);
      tx_jitter = (phase % 4) >= 2;
      rx_jitter = (phase % 4) == 1 || (phase % 4) == 3;
      // Back-to-back pixels against a long radiance hold-off fill the pipeline.
      if (phase == 5) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(rand_pixel(floor_v), tx_gap());
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_scene_radiance_recover OK");
    end else begin
      $display("tb_scene_radiance_recover NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/srr_pkg.sv
rtl/scene_radiance_recover.sv
tb/srr_radiance_checker.sv
tb/tb_scene_radiance_recover.sv
